/* rtl/afd_pkg.sv */
// Package for the autoranging four-digit formatter.
// Holds the value width, digit counts, shared types and the sequencer states.
// No dependencies.
package afd_pkg;

  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned READING_W  = 32;

  // Decimal digits needed for the largest value of VALUE_BITS bits.
  localparam int unsigned NUM_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int unsigned DIG_IDX_W  = $clog2(NUM_DIGITS);
  localparam int unsigned CNT_W      = $clog2(VALUE_BITS);

  localparam int unsigned SHOWN_DIGITS = 4;
  localparam int unsigned STEP_W       = 3;
  localparam int unsigned POINT_W      = 2;
  localparam int unsigned STEP_MAX     = 7;
  localparam int unsigned POINT_LAST   = 3;

  typedef logic [3:0] digit_t;
  typedef digit_t [NUM_DIGITS-1:0] digit_vec_t;

  // Control that the sequencer broadcasts to every digit cell.
  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctrl_t;

  typedef struct packed {
    digit_t               digit_3;
    digit_t               digit_2;
    digit_t               digit_1;
    digit_t               digit_0;
    logic [POINT_W-1:0]   point_after;
    logic [STEP_W-1:0]    range_step;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_EMIT
  } state_e;

endpackage

/* rtl/afd_if.sv */
// Handshake interfaces for the formatter's input and result channels.
// Depend on afd_pkg for the payload widths.
interface afd_in_if;
  logic                              valid;
  logic                              ready;
  logic [afd_pkg::READING_W-1:0]     reading;

  modport source (output valid, output reading, input ready);
  modport sink   (input valid, input reading, output ready);
endinterface

interface afd_out_if;
  logic                              valid;
  logic                              ready;
  afd_pkg::digit_t                   digit_3;
  afd_pkg::digit_t                   digit_2;
  afd_pkg::digit_t                   digit_1;
  afd_pkg::digit_t                   digit_0;
  logic [afd_pkg::POINT_W-1:0]       point_after;
  logic [afd_pkg::STEP_W-1:0]        range_step;

  modport source (output valid, output digit_3, output digit_2, output digit_1,
                  output digit_0, output point_after, output range_step, input ready);
  modport sink   (input valid, input digit_3, input digit_2, input digit_1,
                  input digit_0, input point_after, input range_step, output ready);
endinterface

/* rtl/autorange_four_digit_formatter.sv */
// Top level of the autoranging four-digit formatter: sequencer, digit cell chain
// and result register. Depends on afd_pkg, afd_if, afd_bcd_cell and afd_range_sel.
//
//   channel  | direction | payload
//   ---------+-----------+--------------------------------------------------
//   in_i     | sink      | reading
//   out_o    | source    | digit_3..digit_0, point_after, range_step
//
// A result is registered after the input transfer, once every bit has gone, one bit per
// cycle, through the digit cell chain and the range select has loaded the result register.
// The next reading is taken in the idle state after that, so readings are converted one at a time.
// The result register frees the converter, so a new reading is taken while the
// previous result still waits; a stalled output holds the converter in its last state.
// Reset clears the sequencer and the output valid flag.
module autorange_four_digit_formatter (
  input  logic    clk_i,
  input  logic    rst_ni,
  afd_in_if.sink    in_i,
  afd_out_if.source out_o
);
  import afd_pkg::*;

  state_e                state_q, state_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [VALUE_BITS-1:0] value_q, value_d;
  logic                  out_valid_q, out_valid_d;
  result_t               result_q, result_d;

  cell_ctrl_t            cell_ctrl;
  logic [NUM_DIGITS:0]   carry;
  digit_vec_t            digits;
  result_t               selected;
  logic                  in_xfer;
  logic                  out_load;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign out_load   = (state_q == ST_EMIT) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d         = state_q;
    cnt_d           = cnt_q;
    value_d         = value_q;
    cell_ctrl.clear = 1'b0;
    cell_ctrl.shift = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          value_d         = VALUE_BITS'(in_i.reading);
          cnt_d           = '0;
          cell_ctrl.clear = 1'b1;
          state_d         = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        cell_ctrl.shift = 1'b1;
        value_d         = {value_q[VALUE_BITS-2:0], 1'b0};
        cnt_d           = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(VALUE_BITS - 1)) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q  <= value_d;
    result_q <= result_d;
  end

  // The most significant remaining bit enters the least significant digit.
  assign carry[0] = value_q[VALUE_BITS-1];

  for (genvar g = 0; g < NUM_DIGITS; g++) begin : g_cell
    afd_bcd_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (cell_ctrl),
      .carry_i (carry[g]),
      .carry_o (carry[g+1]),
      .digit_o (digits[g])
    );
  end

  afd_range_sel u_range_sel (
    .digits_i (digits),
    .result_o (selected)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    result_d    = result_q;
    if (out_o.valid && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
      result_d    = selected;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.digit_3     = result_q.digit_3;
  assign out_o.digit_2     = result_q.digit_2;
  assign out_o.digit_1     = result_q.digit_1;
  assign out_o.digit_0     = result_q.digit_0;
  assign out_o.point_after = result_q.point_after;
  assign out_o.range_step  = result_q.range_step;

  // The top carry would only be set by a value beyond the digit count.
  logic unused_carry;
  assign unused_carry = carry[NUM_DIGITS];

endmodule

/* rtl/afd_bcd_cell.sv */
// One decimal digit cell of the shift-and-add-three converter chain.
// Depends on afd_pkg for the digit and control types.
module afd_bcd_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  afd_pkg::cell_ctrl_t  ctrl_i,
  input  logic                 carry_i,
  output logic                 carry_o,
  output afd_pkg::digit_t      digit_o
);
  import afd_pkg::*;

  digit_t digit_q, digit_d;
  digit_t adjusted;

  // A digit of five or more would exceed nine after doubling, so add three first.
  always_comb begin
    adjusted = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
    carry_o  = adjusted[3];
    digit_d  = digit_q;
    if (ctrl_i.clear) begin
      digit_d = '0;
    end else if (ctrl_i.shift) begin
      digit_d = {adjusted[2:0], carry_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= '0;
    end else begin
      digit_q <= digit_d;
    end
  end

  assign digit_o = digit_q;

endmodule

/* rtl/afd_range_sel.sv */
// Range selection: finds the leading decimal digit and picks the four shown digits.
// Depends on afd_pkg for the digit vector and result types.
module afd_range_sel (
  input  afd_pkg::digit_vec_t  digits_i,
  output afd_pkg::result_t     result_o
);
  import afd_pkg::*;

  logic [DIG_IDX_W-1:0] top_idx;
  logic [DIG_IDX_W-1:0] low_idx;
  logic [DIG_IDX_W:0]   step_full;
  digit_t               shown [SHOWN_DIGITS];

  always_comb begin
    top_idx = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (digits_i[i] != 4'd0) begin
        top_idx = DIG_IDX_W'(i);
      end
    end

    // Readings with four digits or fewer are shown undivided.
    low_idx   = (top_idx >= DIG_IDX_W'(SHOWN_DIGITS - 1)) ?
                top_idx - DIG_IDX_W'(SHOWN_DIGITS - 1) : '0;
    step_full = {1'b0, low_idx} + (DIG_IDX_W+1)'(1);

    for (int k = 0; k < SHOWN_DIGITS; k++) begin
      shown[k] = digits_i[low_idx + DIG_IDX_W'(k)];
    end

    result_o.digit_3 = shown[3];
    result_o.digit_2 = shown[2];
    result_o.digit_1 = shown[1];
    result_o.digit_0 = shown[0];
    result_o.range_step = (step_full > (DIG_IDX_W+1)'(STEP_MAX)) ?
                          STEP_W'(STEP_MAX) : STEP_W'(step_full);
    result_o.point_after = (step_full <= (DIG_IDX_W+1)'(POINT_LAST)) ?
                           POINT_W'(step_full) : '0;
  end

endmodule
